[sv/sha256_pkg.sv]
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // what follows the compression now running
    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_PAD,
        FIN_LEN,
        FIN_LAST
    } fin_t;

    typedef logic [31:0] word_t;

    localparam int unsigned ROUNDS     = 64;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned DIGEST_WORDS = 4;
    localparam logic [5:0]  LEN_START  = 6'd56;
    localparam logic [5:0]  LAST_BYTE  = 6'd63;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [1:0]  LAST_INDEX = 2'd3;
    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

[sv/sha256_byte_stream_hasher.sv]
// SHA-256 over a byte stream, one byte per input transaction. The 64th byte of
// a block starts the compression: one round a cycle through a single shared
// round unit, 64 rounds and then a fold of the working variables into the hash,
// and in_stall stays high meanwhile. An end-of-message transaction adds a
// padding step and a compression, or a padding step, a length step and two
// compressions when 56 or more bytes sit in the final block, and then four
// digest transactions, 64 bits each with digest byte 0 in bits 63:56. The
// block takes no input until the fourth digest word has gone, then starts
// the next message from the initial hash.
module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);
    import sha256_pkg::*;

    // sequencer
    state_t state_reg, state_next;
    fin_t   fin_reg, fin_next;

    // message position and length
    logic [5:0]  cnt_reg;
    logic [63:0] bitcnt_reg;
    logic [5:0]  rnd_reg;
    logic [1:0]  idx_reg;

    // 16-word window: block bytes while filling, message schedule while hashing
    word_t w_reg [BLOCK_WORDS];
    word_t hash_reg [8];
    word_t v_reg [8];

    logic in_accept;
    logic out_accept;
    logic block_full;
    logic start_round;

    word_t t1, t2, ch, maj, w_new;
    word_t pad_block [BLOCK_WORDS];

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign block_full = byte_present && (cnt_reg == LAST_BYTE);
    assign start_round = (state_next == ST_ROUND) && (state_reg != ST_ROUND);

    // next state
    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (block_full)
                    begin
                        // full block first, then padding if the message ends here
                        state_next = ST_ROUND;
                        fin_next   = end_of_message ? FIN_PAD : FIN_NONE;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                state_next = ST_ROUND;
                // no room for the length: it goes into an extra block
                fin_next   = (cnt_reg < LEN_START) ? FIN_LAST : FIN_LEN;
            end
            ST_LEN:
            begin
                state_next = ST_ROUND;
                fin_next   = FIN_LAST;
            end
            ST_ROUND:
            begin
                if (rnd_reg == LAST_ROUND)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                case (fin_reg)
                    FIN_PAD:  state_next = ST_PAD;
                    FIN_LEN:  state_next = ST_LEN;
                    FIN_LAST: state_next = ST_EMIT;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_EMIT:
            begin
                if (out_accept && (idx_reg == LAST_INDEX))
                begin
                    state_next = ST_IDLE;
                    fin_next   = FIN_NONE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                fin_next   = FIN_NONE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_EMIT);
    end

    assign digest_word = {hash_reg[{idx_reg, 1'b0}], hash_reg[{idx_reg, 1'b1}]};
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == LAST_INDEX);

    // shared round unit
    always_comb
    begin
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + big_sigma1(v_reg[4]) + ch + ROUND_K[rnd_reg] + w_reg[0];
        t2    = big_sigma0(v_reg[0]) + maj;
        w_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    end

    // padded block: message bytes kept below the count, 0x80 mark, zeros, bit length
    // in the last eight bytes when the count leaves room, else in an all-zero length block
    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            logic [7:0] b;
            b = 8'h00;
            if (state_reg == ST_PAD)
            begin
                if (6'(i) < cnt_reg)
                    b = w_reg[i / 4][8 * (3 - (i % 4)) +: 8];
                else if (6'(i) == cnt_reg)
                    b = PAD_MARK;
            end
            if ((i >= 56) && ((state_reg == ST_LEN) || (cnt_reg < LEN_START)))
                b = bitcnt_reg[8 * (7 - (i % 8)) +: 8];
            pad_block[i / 4][8 * (3 - (i % 4)) +: 8] = b;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fin_reg    <= FIN_NONE;
            cnt_reg    <= '0;
            bitcnt_reg <= '0;
            rnd_reg    <= '0;
            idx_reg    <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= INIT_HASH[i];
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            if (in_accept && byte_present)
            begin
                cnt_reg    <= cnt_reg + 6'd1;
                bitcnt_reg <= bitcnt_reg + BITS_PER_BYTE;
            end
            if (state_reg == ST_ROUND)
                rnd_reg <= rnd_reg + 6'd1;
            else
                rnd_reg <= '0;
            if (state_reg == ST_FOLD)
            begin
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
            end
            if (out_accept)
            begin
                idx_reg <= idx_reg + 2'd1;
                if (idx_reg == LAST_INDEX)
                begin
                    // back to the initial state for the next message
                    cnt_reg    <= '0;
                    bitcnt_reg <= '0;
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= INIT_HASH[i];
                end
            end
        end
    end

    // window and working variables
    always_ff @(posedge clk)
    begin
        if (in_accept && byte_present)
            w_reg[cnt_reg[5:2]][{~cnt_reg[1:0], 3'b000} +: 8] <= data_byte;
        else if (state_reg inside {ST_PAD, ST_LEN})
        begin
            for (int i = 0; i < BLOCK_WORDS; i++)
                w_reg[i] <= pad_block[i];
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[BLOCK_WORDS - 1] <= w_new;
        end

        if (start_round)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= hash_reg[i];
        end
        else if (state_reg == ST_ROUND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // no input transaction while digest words are pending
    a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while digest pending");

    // the round counter ends a compression after exactly 64 rounds
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_reg == LAST_ROUND) |=> (state_reg == ST_FOLD))
        else $error("compression did not end after the last round");

    // an end-of-message transaction always starts the finishing sequence
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && end_of_message) |=> in_stall)
        else $error("end of message did not start finishing");

    // the last digest word closes the message
    a_last_word_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && last_word) |=> (!out_valid && cnt_reg == '0 && bitcnt_reg == '0))
        else $error("state not restarted after last digest word");

endmodule

[tb/sha256_byte_stream_hasher_tb.sv]
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_tb;

    // clocking and run limits
    localparam int unsigned HALF_PERIOD  = 4;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;

    // padding layout of the final block, and the digest word count
    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam int unsigned LEN_OFFSET = 56;
    localparam int unsigned BLOCK_SIZE = 64;
    localparam int unsigned WORDS_OUT  = 4;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // one digest word as the block should emit it
    typedef struct {
        logic [63:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    // predicted hashing state, tracked per accepted input transaction
    logic [7:0]  block_bytes [64];
    logic [5:0]  byte_fill;
    logic [63:0] bit_length;
    logic [31:0] hash_chain [8];

    // digest words still owed by the block, oldest first
    digest_beat_t pending_digests [$];

    // idling percentages for the current phase
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;

    int unsigned failures;
    int unsigned bytes_hashed;
    int unsigned messages_finished;
    int unsigned words_checked;

    sha256_byte_stream_hasher i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // hard stop in case the block hangs or loses a digest
    initial
    begin
        #RUN_LIMIT_NS;
        $display("timeout with %0d digest words outstanding", pending_digests.size());
        $display("status: fail");
        $finish;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // back to the initial hash for the next message; the buffer keeps its bytes
    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
        begin
            hash_chain[i] = START_HASH[i];
        end
        byte_fill  = '0;
        bit_length = '0;
    endtask

    // 64-round compression of block_bytes into hash_chain
    task automatic compress_block();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, lo, hi;
        for (int r = 0; r < 16; r++)
        begin
            sched[r] = {block_bytes[4*r], block_bytes[4*r+1],
                        block_bytes[4*r+2], block_bytes[4*r+3]};
        end
        for (int r = 16; r < 64; r++)
        begin
            lo = sched[r-15];
            hi = sched[r-2];
            sched[r] = sched[r-16] + (rotr(lo, 7) ^ rotr(lo, 18) ^ (lo >> 3))
                     + sched[r-7] + (rotr(hi, 17) ^ rotr(hi, 19) ^ (hi >> 10));
        end
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
        e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
        for (int r = 0; r < 64; r++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_CONST[r] + sched[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
        hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
    endtask

    // fold one accepted transaction into the predicted state, queue the digest on finish
    task automatic predict_transaction(input logic [7:0] value, input logic present,
                                       input logic finish);
        int unsigned pos;
        digest_beat_t beat;
        if (present)
        begin
            block_bytes[byte_fill] = value;
            bit_length += 64'd8;
            byte_fill  += 6'd1;
            bytes_hashed++;
            if (byte_fill == 6'd0)
                compress_block();
        end
        if (finish)
        begin
            pos = byte_fill;
            block_bytes[pos] = PAD_BYTE;
            pos++;
            // no room left for the length: pad out and spend an extra block
            if (pos > LEN_OFFSET)
            begin
                while (pos < BLOCK_SIZE)
                begin
                    block_bytes[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < LEN_OFFSET)
            begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            for (int k = 0; k < 8; k++)
            begin
                block_bytes[LEN_OFFSET + k] = bit_length[63 - 8*k -: 8];
            end
            compress_block();
            for (int k = 0; k < WORDS_OUT; k++)
            begin
                beat.word  = {hash_chain[2*k], hash_chain[2*k+1]};
                beat.index = k[1:0];
                beat.last  = (k == WORDS_OUT - 1);
                pending_digests = {pending_digests, beat};
            end
            messages_finished++;
            restart_hash();
        end
    endtask

    // one input transaction; entered and left just after a falling edge
    task automatic send_item(input logic [7:0] value, input logic present,
                             input logic finish);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= value;
        byte_present   <= present;
        end_of_message <= finish;
        do
            @(posedge clk);
        while (in_stall);
        predict_transaction(value, present, finish);
        @(negedge clk);
    endtask

    // a message of random bytes, with the odd idle transaction mixed in as noise;
    // the finish rides on the last byte unless asked for on a transaction of its own
    task automatic send_message(input int unsigned length, input bit separate_finish);
        for (int unsigned i = 0; i < length; i++)
        begin
            if ($urandom_range(15) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, (i == length - 1) && !separate_finish);
        end
        if (length == 0 || separate_finish)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // sender holds off until every owed digest word has arrived
    task automatic wait_for_digests();
        in_valid <= 1'b0;
        while (pending_digests.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    // finish with no byte at all: the empty-message digest, twice in a row
    task automatic test_empty_message();
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    // one-byte messages at both extremes, then the classic three-letter vector
    task automatic test_short_vectors();
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
    endtask

    // idle transactions must change nothing, and a late finish closes the message
    task automatic test_idle_items();
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'ha5, 1'b0, 1'b0);
        send_item(8'h3c, 1'b0, 1'b1);
    endtask

    // one padding boundary message then a short random one, under one
    // idling mix, ending with a pause until the block has drained
    task automatic test_random_traffic(input int unsigned sender_pct,
                                       input int unsigned receiver_pct,
                                       input int unsigned boundary_length,
                                       input bit separate_finish);
        set_idling(sender_pct, receiver_pct);
        send_message(boundary_length, separate_finish);
        send_message($urandom_range(10), $urandom_range(3) == 0);
        wait_for_digests();
    endtask

    // receiver side: stall pattern changes at the falling edge
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // checker: every accepted digest transaction against the oldest expectation
    initial
    begin
        digest_beat_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_digests.size() == 0)
                begin
                    $error("digest transaction with nothing expected: word %h index %0d",
                           digest_word, word_index);
                    failures++;
                end
                else
                begin
                    want = pending_digests.pop_front();
                    words_checked++;
                    if (digest_word !== want.word)
                    begin
                        $error("digest_word expected %h actual %h", want.word, digest_word);
                        failures++;
                    end
                    if (word_index !== want.index)
                    begin
                        $error("word_index expected %0d actual %0d", want.index, word_index);
                        failures++;
                    end
                    if (last_word !== want.last)
                    begin
                        $error("last_word expected %0b actual %0b", want.last, last_word);
                        failures++;
                    end
                end
            end
        end
    end

    // stimulus sequence
    initial
    begin
        failures          = 0;
        bytes_hashed      = 0;
        messages_finished = 0;
        words_checked     = 0;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        data_byte         = 8'h00;
        byte_present      = 1'b0;
        end_of_message    = 1'b0;
        set_idling(0, 0);
        for (int i = 0; i < BLOCK_SIZE; i++)
        begin
            block_bytes[i] = 8'h00;
        end
        restart_hash();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed part, no idling
        test_empty_message();
        test_short_vectors();
        test_idle_items();
        wait_for_digests();

        // random content around the padding edges: 55 bytes still fit the length,
        // 56 force an extra block, a full block finishing on its last byte, and a
        // full block closed by a finish-only transaction
        test_random_traffic(0, 0, 55, 1'b0);
        test_random_traffic(66, 0, 56, 1'b0);
        test_random_traffic(0, 66, 64, 1'b0);
        test_random_traffic(36, 36, 64, 1'b1);

        $display("hashed %0d bytes in %0d messages, %0d digest words checked",
                 bytes_hashed, messages_finished, words_checked);
        $display("covered empty and short messages, idle transactions, padding edges, stalls");
        if (failures == 0 && pending_digests.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
sv/sha256_pkg.sv
sv/sha256_byte_stream_hasher.sv
tb/sha256_byte_stream_hasher_tb.sv
